// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker of the priority queue.
// Depends on nothing; each macro expects clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is held
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is held
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/spq_pkg.sv -----
// Types and constants of the sorted priority queue.
// Used by the controller and the top level.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned ACTION_BITS = 2;
  localparam int unsigned PRIO_BITS   = 16;

  // Operation codes carried in the action field
  typedef enum logic [ACTION_BITS-1:0] {
    ACT_OFFER = 2'd0,
    ACT_POLL  = 2'd1,
    ACT_PEEK  = 2'd2
  } spq_act_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFFER,
    ST_PLACE,
    ST_HEAD,
    ST_SHIFT,
    ST_FINISH
  } spq_state_t;

  // Result flags handed from the controller to the output stage
  typedef struct packed {
    logic res_valid;
    logic dropped;
  } spq_flags_t;

endpackage

// ----- sv/sorted_priority_queue_top.sv -----
// Items are taken one at a time: intake is ready only while the sequencer is idle,
// so a new item waits until the last result has gone to the output register.
// The single write port of the entry memory moves one entry per cycle; a stalled
// result holds intake.
// Reset: synchronous, active low; clears the entry count and the handshakes,
// memory contents are left as they are and need no clearing pass.
`timescale 1ns / 1ps

module sorted_priority_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16,
  localparam int unsigned IDX_W      = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned ENT_W      = spq_pkg::PRIO_BITS + TAG_BITS,
  localparam int unsigned IN_W       = spq_pkg::ACTION_BITS + spq_pkg::PRIO_BITS + TAG_BITS,
  localparam int unsigned IN_TDATA_W = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W      = 2 + TAG_BITS + CNT_W,
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // action, priority_req, tag (lowest bits first), zero padded
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // result_valid, result_tag, entry_count, dropped (lowest bits first), zero padded
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  import spq_pkg::*;

  logic [ACTION_BITS-1:0]      in_action;
  logic signed [PRIO_BITS-1:0] in_prio;
  logic [TAG_BITS-1:0]         in_tag;

  logic                        fin_valid;
  logic                        fin_ready;
  spq_flags_t                  fin_flags;
  logic [TAG_BITS-1:0]         fin_tag;
  logic [CNT_W-1:0]            fin_count;

  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [ENT_W-1:0]            mem_wdata;
  logic [IDX_W-1:0]            mem_raddr;
  logic [ENT_W-1:0]            mem_rdata;

  logic                        out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]            out_data_r, out_data_nxt;

  // Unpack the input item
  assign in_action = in_tdata[ACTION_BITS-1:0];
  assign in_prio   = signed'(in_tdata[ACTION_BITS +: PRIO_BITS]);
  assign in_tag    = in_tdata[ACTION_BITS + PRIO_BITS +: TAG_BITS];

  spq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_action),
    .in_prio   (in_prio),
    .in_tag    (in_tag),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin_flags (fin_flags),
    .fin_tag   (fin_tag),
    .fin_count (fin_count),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  spq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: load a finished result when free or being emptied
  assign fin_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (fin_valid && fin_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {fin_flags.dropped, fin_count, fin_tag, fin_flags.res_valid};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule

// ----- sv/spq_mem.sv -----
// Entry store of the priority queue: one write port, one read port,
// registered read data. No dependencies.
`timescale 1ns / 1ps

module spq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] entry_mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      entry_mem[waddr] <= wdata;
    end
  end

  // Read one entry, data valid the next cycle
  always_ff @(posedge clk) begin
    rdata_r <= entry_mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/spq_ctrl.sv -----
// Sequencer of the priority queue: walks the entry memory one entry per
// cycle to insert or remove. Depends on spq_pkg and the spq_mem port timing.
`timescale 1ns / 1ps

module spq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16,
  localparam int unsigned IDX_W      = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned ENT_W      = spq_pkg::PRIO_BITS + TAG_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // item intake
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [spq_pkg::ACTION_BITS-1:0]     in_action,
  input  logic signed [spq_pkg::PRIO_BITS-1:0] in_prio,
  input  logic [TAG_BITS-1:0]                 in_tag,
  // finished result
  output logic                                fin_valid,
  input  logic                                fin_ready,
  output spq_pkg::spq_flags_t                 fin_flags,
  output logic [TAG_BITS-1:0]                 fin_tag,
  output logic [CNT_W-1:0]                    fin_count,
  // entry memory
  output logic                                mem_we,
  output logic [IDX_W-1:0]                    mem_waddr,
  output logic [ENT_W-1:0]                    mem_wdata,
  output logic [IDX_W-1:0]                    mem_raddr,
  input  logic [ENT_W-1:0]                    mem_rdata
);

  import spq_pkg::*;

  spq_state_t                  state_r, state_nxt;
  spq_act_t                    act_r, act_nxt;
  logic signed [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic [TAG_BITS-1:0]         tag_r, tag_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [TAG_BITS-1:0]         res_tag_r, res_tag_nxt;
  spq_flags_t                  flags_r, flags_nxt;

  logic signed [PRIO_BITS-1:0] rd_prio;
  logic [TAG_BITS-1:0]         rd_tag;
  logic                        in_take;
  logic                        is_full;
  logic                        is_empty;
  logic                        offer_stop;
  logic                        shift_more;

  assign rd_prio    = signed'(mem_rdata[TAG_BITS +: PRIO_BITS]);
  assign rd_tag     = mem_rdata[TAG_BITS-1:0];
  assign in_take    = in_valid && in_ready;
  assign is_full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty   = (count_r == '0);
  // new entry stays behind every entry of strictly higher priority
  assign offer_stop = (prio_r < rd_prio);
  assign shift_more = ((CNT_W'(idx_r) + CNT_W'(1)) < count_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (spq_act_t'(in_action))
            ACT_OFFER: begin
              if (is_full) begin
                state_nxt = ST_FINISH;
              end else if (is_empty) begin
                state_nxt = ST_PLACE;
              end else begin
                state_nxt = ST_OFFER;
              end
            end
            ACT_POLL, ACT_PEEK: begin
              state_nxt = is_empty ? ST_FINISH : ST_HEAD;
            end
            default: state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_OFFER: begin
        if (offer_stop) begin
          state_nxt = ST_FINISH;
        end else if (idx_r == IDX_W'(1)) begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: state_nxt = ST_FINISH;
      ST_HEAD: begin
        if (act_r == ACT_POLL && count_r > CNT_W'(1)) begin
          state_nxt = ST_SHIFT;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SHIFT: begin
        if (!shift_more) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    fin_valid   = (state_r == ST_FINISH);
    mem_we      = 1'b0;
    mem_waddr   = idx_r;
    mem_wdata   = {prio_r, tag_r};
    mem_raddr   = idx_r;
    act_nxt     = act_r;
    prio_nxt    = prio_r;
    tag_nxt     = tag_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    res_tag_nxt = res_tag_r;
    flags_nxt   = flags_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          act_nxt     = spq_act_t'(in_action);
          prio_nxt    = in_prio;
          tag_nxt     = in_tag;
          res_tag_nxt = '0;
          flags_nxt   = '0;
          case (spq_act_t'(in_action))
            ACT_OFFER: begin
              if (is_full) begin
                flags_nxt.dropped = 1'b1;
              end else begin
                // start at the tail: slot to fill is count, compare entry below
                idx_nxt   = count_r[IDX_W-1:0];
                mem_raddr = IDX_W'(count_r - CNT_W'(1));
              end
            end
            ACT_POLL, ACT_PEEK: begin
              mem_raddr = '0;
            end
            default: ;
          endcase
        end
      end
      ST_OFFER: begin
        mem_we = 1'b1;
        if (offer_stop) begin
          // drop the new entry into the open slot
          count_nxt           = CNT_W'(count_r + CNT_W'(1));
          flags_nxt.res_valid = 1'b1;
          res_tag_nxt         = tag_r;
        end else begin
          // move the entry one slot towards the tail, fetch the next one up
          mem_wdata = mem_rdata;
          idx_nxt   = IDX_W'(idx_r - IDX_W'(1));
          mem_raddr = IDX_W'(idx_r - IDX_W'(2));
        end
      end
      ST_PLACE: begin
        mem_we              = 1'b1;
        count_nxt           = CNT_W'(count_r + CNT_W'(1));
        flags_nxt.res_valid = 1'b1;
        res_tag_nxt         = tag_r;
      end
      ST_HEAD: begin
        flags_nxt.res_valid = 1'b1;
        res_tag_nxt         = rd_tag;
        if (act_r == ACT_POLL) begin
          if (count_r > CNT_W'(1)) begin
            idx_nxt   = IDX_W'(1);
            mem_raddr = IDX_W'(1);
          end else begin
            count_nxt = '0;
          end
        end
      end
      ST_SHIFT: begin
        // pull the entry one slot towards the head
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(idx_r - IDX_W'(1));
        mem_wdata = mem_rdata;
        if (shift_more) begin
          idx_nxt   = IDX_W'(idx_r + IDX_W'(1));
          mem_raddr = IDX_W'(idx_r + IDX_W'(1));
        end else begin
          count_nxt = CNT_W'(count_r - CNT_W'(1));
        end
      end
      ST_FINISH: ;
      default: ;
    endcase
  end

  assign fin_flags = flags_r;
  assign fin_tag   = res_tag_r;
  assign fin_count = count_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    prio_r    <= prio_nxt;
    tag_r     <= tag_nxt;
    idx_r     <= idx_nxt;
    res_tag_r <= res_tag_nxt;
    flags_r   <= flags_nxt;
  end

endmodule

// ----- sv/spq_check.sv -----
// Port-level checker of the priority queue and its bind to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spq_check #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OUT_W      = 2 + TAG_BITS + CNT_W,
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8,
  localparam int unsigned CNT_LSB    = 1 + TAG_BITS,
  localparam int unsigned DROP_BIT   = 1 + TAG_BITS + CNT_W
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // Hold a stalled result
  `SPQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result withdrawn while stalled")
  `SPQ_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "stalled result changed")

  // A dropped offer carries no tag
  `SPQ_ASSERT_NOW(a_drop_empty, out_tvalid && out_tdata[DROP_BIT], !out_tdata[0] && out_tdata[1 +: TAG_BITS] == '0, "dropped offer reported a tag")

  // Count never exceeds the depth, and a drop is only reported while the queue is full
  `SPQ_ASSERT_NOW(a_count_max, out_tvalid, out_tdata[CNT_LSB +: CNT_W] <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `SPQ_ASSERT_NOW(a_drop_full, out_tvalid && out_tdata[DROP_BIT], out_tdata[CNT_LSB +: CNT_W] == CNT_W'(QUEUE_DEPTH), "drop reported while not full")

endmodule

bind sorted_priority_queue_top spq_check #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .TAG_BITS    (TAG_BITS)
) u_spq_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
